### rtl/mrq_pkg.sv
// ---------------------------------------------------------------------------
// mrq_pkg: shared constants for the multilevel ready queue
// Command and status codes, default sizes.
// ---------------------------------------------------------------------------
`default_nettype none
package mrq_pkg;
	localparam int unsigned LEVELS_DEF  = 64;
	localparam int unsigned THREADS_DEF = 64;
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned ID_W   = 6;
	localparam int unsigned LVL_W  = 6;
	localparam int unsigned STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REQ = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;
endpackage
`default_nettype wire

### rtl/mrq_prio_enc.sv
// ---------------------------------------------------------------------------
// mrq_prio_enc: registered highest-set-bit search over the occupancy map
// Flat scan of the whole map, index and hit flag registered once.
// ---------------------------------------------------------------------------
`default_nettype none
module mrq_prio_enc import mrq_pkg::*; #(
	parameter int unsigned LEVELS = LEVELS_DEF
) (
	input  wire logic                      clk,
	input  wire logic [LEVELS-1:0]         map,
	output logic                           any_q,
	output logic [$clog2(LEVELS)-1:0]      idx_q
);
	localparam int unsigned LW = $clog2(LEVELS);
	logic [LW-1:0] idx_c;
	logic          any_c;

	// scan upwards, the last hit is the highest level
	always_comb begin
		idx_c = '0;
		any_c = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (map[i]) begin
				idx_c = LW'(i);
				any_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		any_q <= any_c;
		idx_q <= idx_c;
	end
endmodule
`default_nettype wire

### rtl/mrq_ram.sv
// ---------------------------------------------------------------------------
// mrq_ram: single-port-write, one-read synchronous memory
// Read data registered.
// ---------------------------------------------------------------------------
`default_nettype none
module mrq_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/multilevel_ready_queue_unit.sv
// ---------------------------------------------------------------------------
// multilevel_ready_queue_unit: per-level FIFO ready queues of thread IDs
// Sequencer over head/tail and link memories.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) takes one command word: cmd, thread_id, level.
//   Output channel (out_valid/out_ready) returns one word per command:
//   served_id and status.
//   Enqueue appends at a level tail, dequeue pops the highest non-empty level,
//   requeue moves a queued thread. Each command is a read-modify-write
//   sequence over the level memory (head, tail) and the thread memory
//   (next, prev, level): a rejected word or empty dequeue goes from the
//   first read step to the result; a same-level requeue also reads the
//   thread entry; enqueue reads and writes the new level entry; dequeue
//   reads the head thread entry and unlinks it; a moving requeue unlinks
//   the thread (with a neighbour link fix when it sits mid-queue) and appends.
//   One command is in flight at a time; a new word is taken in the idle step
//   after the result has moved to the output register. While the receiver
//   stalls, one further command may run up to its result step and wait
//   there; the input then stays blocked.
//   Reset clears the occupancy and queued bits; memories need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none
module multilevel_ready_queue_unit import mrq_pkg::*; #(
	parameter int unsigned LEVELS  = LEVELS_DEF,
	parameter int unsigned THREADS = THREADS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [ID_W-1:0]   thread_id,
	input  wire logic [LVL_W-1:0]  level,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ID_W-1:0]        served_id,
	output logic [STAT_W-1:0]      status
);
	localparam int unsigned LW = $clog2(LEVELS);
	localparam int unsigned TW = $clog2(THREADS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD1   = 4'd1;  // read level entry / thread entry
	localparam logic [3:0] S_UNL   = 4'd2;  // unlink decision
	localparam logic [3:0] S_UNL2  = 4'd3;  // neighbour link fix
	localparam logic [3:0] S_APRD  = 4'd4;  // read new level entry
	localparam logic [3:0] S_APWR  = 4'd5;  // append writes
	localparam logic [3:0] S_OUT   = 4'd6;
	localparam logic [3:0] S_DQRD  = 4'd7;  // read head thread entry
	localparam logic [3:0] S_APWR2 = 4'd8;

	logic [3:0] st_q;
	logic [LEVELS-1:0]  ne_q;
	logic [THREADS-1:0] qd_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [TW-1:0]      t_q;
	logic [LW-1:0]      ol_q;
	logic [LW-1:0]      nl_q;
	logic [TW-1:0]      p_q, n_q;
	logic               ok_c_q;
	logic [ID_W-1:0]    id_q;
	logic [STAT_W-1:0]  stat_q;

	// level memory: {head, tail}; thread memory: {next, prev, level}
	logic           lm_we;
	logic [LW-1:0]  lm_wa, lm_ra;
	logic [2*TW-1:0] lm_wd, lm_rd;
	logic           tn_we, tp_we, tl_we;
	logic [TW-1:0]  tn_wa, tp_wa, tl_wa, tm_ra;
	logic [TW-1:0]  tn_wd, tp_wd, tn_rd, tp_rd;
	logic [LW-1:0]  tl_wd, tl_rd;

	mrq_ram #(.DEPTH(LEVELS), .WIDTH(2*TW)) u_lvl (.clk, .we(lm_we), .waddr(lm_wa),
		.wdata(lm_wd), .raddr(lm_ra), .rdata(lm_rd));
	mrq_ram #(.DEPTH(THREADS), .WIDTH(TW)) u_nxt (.clk, .we(tn_we), .waddr(tn_wa),
		.wdata(tn_wd), .raddr(tm_ra), .rdata(tn_rd));
	mrq_ram #(.DEPTH(THREADS), .WIDTH(TW)) u_prv (.clk, .we(tp_we), .waddr(tp_wa),
		.wdata(tp_wd), .raddr(tm_ra), .rdata(tp_rd));
	mrq_ram #(.DEPTH(THREADS), .WIDTH(LW)) u_tlv (.clk, .we(tl_we), .waddr(tl_wa),
		.wdata(tl_wd), .raddr(tm_ra), .rdata(tl_rd));

	logic          pe_any;
	logic [LW-1:0] pe_idx;
	mrq_prio_enc #(.LEVELS(LEVELS)) u_pe (.clk, .map(ne_q), .any_q(pe_any), .idx_q(pe_idx));

	logic ok_c, acc;
	assign ok_c = (32'(thread_id) < THREADS) && (32'(level) < LEVELS);
	assign in_ready = (st_q == S_IDLE);
	assign acc = in_valid && in_ready;

	logic enq_ok, req_ok, out_free;
	assign enq_ok = (cmd_q == CMD_ENQ) && ok_c_q && !qd_q[t_q];
	assign req_ok = (cmd_q == CMD_REQ) && ok_c_q && qd_q[t_q];
	// output register free this cycle
	assign out_free = !out_valid || out_ready;

	logic [TW-1:0] hd, tl;
	assign hd = lm_rd[2*TW-1:TW];
	assign tl = lm_rd[TW-1:0];

	// read addresses follow the current step
	always_comb begin
		lm_ra = ol_q;
		tm_ra = t_q;
		unique case (st_q)
			S_APRD:  lm_ra = nl_q;
			S_IDLE:  lm_ra = pe_idx;
			default: ;
		endcase
	end

	logic at_h, at_t;
	assign at_h = (hd == t_q);
	assign at_t = (tl == t_q);

	always_comb begin
		lm_we = 1'b0; lm_wa = ol_q; lm_wd = lm_rd;
		tn_we = 1'b0; tn_wa = p_q;  tn_wd = n_q;
		tp_we = 1'b0; tp_wa = n_q;  tp_wd = p_q;
		tl_we = 1'b0; tl_wa = t_q;  tl_wd = nl_q;
		unique case (st_q)
			S_UNL: begin
				if (at_h && !at_t) begin
					lm_we = 1'b1; lm_wd = {tn_rd, tl};
				end else if (at_t && !at_h) begin
					lm_we = 1'b1; lm_wd = {hd, tp_rd};
				end
			end
			S_UNL2: begin
				tn_we = 1'b1; tp_we = 1'b1;
			end
			S_APWR: begin
				lm_we = 1'b1; lm_wa = nl_q;
				tl_we = 1'b1;
				if (ne_q[nl_q]) begin
					lm_wd = {hd, t_q};
					tn_we = 1'b1; tn_wa = tl; tn_wd = t_q;
					tp_we = 1'b1; tp_wa = t_q; tp_wd = tl;
				end else begin
					lm_wd = {t_q, t_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ne_q <= '0;
			qd_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (st_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (acc) st_q <= S_RD1;
				S_RD1: begin
					// lm_rd now holds entry at pe_idx (dequeue)
					priority if (cmd_q == CMD_DEQ) st_q <= pe_any ? S_DQRD : S_OUT;
					else if (enq_ok) st_q <= S_APRD;
					else if (req_ok) st_q <= S_DQRD;
					else st_q <= S_OUT;
				end
				S_DQRD: begin
					// thread entry read now valid (requeue)
					if (cmd_q == CMD_REQ && tl_rd == nl_q) st_q <= S_OUT;
					else st_q <= S_APWR2;
				end
				S_APWR2: st_q <= S_UNL;
				S_UNL: begin
					if (at_h && at_t) ne_q[ol_q] <= 1'b0;
					qd_q[t_q] <= 1'b0;
					st_q <= (!at_h && !at_t) ? S_UNL2 :
						((cmd_q == CMD_REQ) ? S_APRD : S_OUT);
				end
				S_UNL2: st_q <= (cmd_q == CMD_REQ) ? S_APRD : S_OUT;
				S_APRD: st_q <= S_APWR;
				S_APWR: begin
					ne_q[nl_q] <= 1'b1;
					qd_q[t_q] <= 1'b1;
					st_q <= S_OUT;
				end
				S_OUT: if (out_free) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				if (acc) begin
					cmd_q <= cmd; t_q <= TW'(thread_id); nl_q <= LW'(level);
					ok_c_q <= ok_c;
					id_q <= thread_id; stat_q <= ST_REJECT;
				end
			end
			S_RD1: begin
				priority if (cmd_q == CMD_DEQ) begin
					if (!pe_any) begin
						id_q <= '0; stat_q <= ST_EMPTY;
					end else begin
						ol_q <= pe_idx; t_q <= hd;
						id_q <= ID_W'(hd); stat_q <= ST_DONE;
					end
				end else if (enq_ok || req_ok) begin
					stat_q <= ST_DONE;
				end else begin
					stat_q <= ST_REJECT;
				end
			end
			S_DQRD: if (cmd_q == CMD_REQ) ol_q <= tl_rd;
			S_APWR2: begin
				// level entry of old level being read
				p_q <= tp_rd; n_q <= tn_rd;
			end
			S_OUT: begin
				if (out_free) begin
					served_id <= id_q; status <= stat_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### rtl/mrq_checker.sv
// ---------------------------------------------------------------------------
// mrq_checker: port-level checks for the ready queue
// Bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module mrq_checker import mrq_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [ID_W-1:0]   served_id,
	input wire logic [STAT_W-1:0] status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(served_id) && $stable(status))
		else $error("result word changed while stalled");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_REJECT)
		else $error("bad status code");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> served_id == '0)
		else $error("empty dequeue with nonzero id");
endmodule

bind multilevel_ready_queue_unit mrq_checker u_chk (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready, .served_id, .status);
`default_nettype wire

### bench/mrq_checker.sv
// ---------------------------------------------------------------------------
// mrq_scoreboard: scoreboard for the multilevel ready queue
// Watches both channels, keeps its own copy of the per-level FIFOs and
// compares every result word with the oldest expected one.
// ---------------------------------------------------------------------------
module mrq_scoreboard import mrq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [ID_W-1:0]   thread_id,
	input  logic [LVL_W-1:0]  level,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [ID_W-1:0]   served_id,
	input  logic [STAT_W-1:0] status,
	output int                n_errors,
	output int                n_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NL = 64;
	localparam int NT = 64;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [STAT_W-1:0] st;
	} sched_res_t;

	// shadow ready queues: one FIFO of thread IDs per level
	logic [ID_W-1:0] ready_q[NL][$];
	logic [NT-1:0]   is_queued;
	logic [LVL_W-1:0] lvl_of[NT];
	sched_res_t      expected_q[$];

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		n_errors++;
	endtask

	function automatic void drop_thread(input logic [ID_W-1:0] t);
		int lv;
		lv = int'(lvl_of[t]);
		for (int k = 0; k < ready_q[lv].size(); k++)
			if (ready_q[lv][k] == t) begin
				ready_q[lv].delete(k);
				break;
			end
		is_queued[t] = 1'b0;
	endfunction

	function automatic sched_res_t schedule(input logic [CMD_W-1:0] c,
			input logic [ID_W-1:0] t, input logic [LVL_W-1:0] lv);
		sched_res_t r;
		r.id = t;
		r.st = ST_REJECT;
		case (c)
		CMD_ENQ: begin
			if (!is_queued[t]) begin
				ready_q[lv].push_back(t);
				lvl_of[t] = lv;
				is_queued[t] = 1'b1;
				r.st = ST_DONE;
			end
		end
		CMD_DEQ: begin
			r.id = '0;
			r.st = ST_EMPTY;
			for (int i = NL - 1; i >= 0; i--)
				if (ready_q[i].size() != 0) begin
					r.id = ready_q[i].pop_front();
					is_queued[r.id] = 1'b0;
					r.st = ST_DONE;
					break;
				end
		end
		CMD_REQ: begin
			if (is_queued[t]) begin
				// same level: keeps its place
				if (lvl_of[t] != lv) begin
					drop_thread(t);
					ready_q[lv].push_back(t);
					lvl_of[t] = lv;
					is_queued[t] = 1'b1;
				end
				r.st = ST_DONE;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_res_t want;
		if (!arst_n) begin
			n_errors = 0;
			is_queued = '0;
			for (int i = 0; i < NL; i++) ready_q[i].delete();
			expected_q.delete();
			n_pending = 0;
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back(schedule(cmd, thread_id, level));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0)
					report($sformatf("unexpected word id=%0d st=%0d", served_id, status));
				else begin
					want = expected_q.pop_front();
					if (served_id !== want.id)
						report($sformatf("served_id %0d, want %0d", served_id, want.id));
					if (status !== want.st)
						report($sformatf("status %0d, want %0d", status, want.st));
				end
			end
			n_pending = expected_q.size();
		end
	end
endmodule

### bench/tb_multilevel_ready_queue_unit.sv
// ---------------------------------------------------------------------------
// tb_multilevel_ready_queue_unit: top of the ready queue testbench
// Directed corner cases, then random scheduling traffic with random gaps
// and stalls on both sides and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_multilevel_ready_queue_unit import mrq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 800;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd = CMD_ENQ;
	logic [ID_W-1:0]   thread_id = '0;
	logic [LVL_W-1:0]  level = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ID_W-1:0]   served_id;
	logic [STAT_W-1:0] status;
	int                n_errors;
	int                n_pending;
	int                cycles = 0;
	bit                sending_done = 0;
	bit                hold_off = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multilevel_ready_queue_unit u_dut (.*);

	mrq_scoreboard u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_word(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] t,
			input logic [LVL_W-1:0] lv);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		thread_id <= t;
		level <= lv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// long receiver hold-off, counted here
	initial begin
		wait (hold_off);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 0;
	end

	// receiver: random stalls, held off entirely while hold_off is set
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3);
			if (stall != 0 || hold_off) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		logic [CMD_W-1:0] c;
		logic [ID_W-1:0]  t;
		logic [LVL_W-1:0] lv;
		int tail;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty dequeue, extremes, duplicates, same-level requeue
		send_word(CMD_DEQ, 6'd63, 6'd63);
		send_word(CMD_REQ, 6'd5, 6'd1);
		send_word(CMD_ENQ, 6'd0, 6'd0);
		send_word(CMD_ENQ, 6'd63, 6'd63);
		send_word(CMD_ENQ, 6'd63, 6'd2);
		send_word(CMD_ENQ, 6'd1, 6'd0);
		send_word(CMD_ENQ, 6'd2, 6'd0);
		send_word(CMD_REQ, 6'd1, 6'd0);
		send_word(CMD_REQ, 6'd0, 6'd0);
		send_word(CMD_REQ, 6'd1, 6'd63);
		send_word(CMD_REQ, 6'd42, 6'd63);
		send_word(CMD_UNDEF, 6'd21, 6'd42);
		send_word(CMD_UNDEF, 6'd42, 6'd21);
		repeat (6) send_word(CMD_DEQ, 6'($urandom), 6'($urandom));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) hold_off = 1;
			tail = $urandom_range(0, 99);
			// few levels and threads mostly, to build long queues and collisions
			t = (tail < 70) ? 6'($urandom_range(0, 15)) : 6'($urandom);
			lv = (tail < 60) ? 6'($urandom_range(0, 3)) : 6'($urandom);
			tail = $urandom_range(0, 99);
			c = (tail < 40) ? CMD_ENQ : (tail < 70) ? CMD_DEQ :
				(tail < 97) ? CMD_REQ : CMD_UNDEF;
			send_word(c, t, lv);
		end
		in_valid <= 1'b0;
		sending_done = 1;
	end

	initial begin
		wait (sending_done);
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
